### src/zcs_pkg.sv
// Shared types and constants for the 3x3 zero crossing slope block.
`default_nettype none

package zcs_pkg;

  localparam int PIXEL_W    = 16;
  localparam int SLOPE_W    = PIXEL_W + 1;
  localparam int ROWS_W     = 13;
  localparam int COLS_CFG_W = 11;
  localparam int THR_W      = 15;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int NBR_N      = 8;

  localparam logic [ROWS_W-1:0] MAX_ROWS = 13'd4096;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEGATIVE_MODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_ONE_SIDED = 3'd4;

  typedef logic signed [PIXEL_W-1:0] pix_t;
  typedef pix_t [NBR_N-1:0] nbr_arr_t;

  typedef struct packed {
    logic action;
    pix_t pixel_value;
  } zcs_in_t;

  typedef struct packed {
    logic [SLOPE_W-1:0] slope;
    logic               frame_last;
  } zcs_out_t;

  typedef struct packed {
    logic [THR_W-1:0] thr;
    logic             negative_mode;
    logic             mark_one_sided;
  } zcs_mode_t;

  // which window borders lie inside the image
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } zcs_mask_t;

endpackage

`default_nettype wire

### src/zero_crossing_slope_3x3.sv
// Top level: 3x3 zero crossing slope over a raster pixel stream.
//
//   channel | dir | payload           | handshake
//   in_     | in  | zcs_in_t          | in_valid / in_stall
//   out_    | out | zcs_out_t         | out_valid / out_stall
//   cfg_    | in  | index, 15b data   | cfg_wr_en, no wait
//
// One item per clock when not stalled. Results pass the s1, s2, slope and output
// registers after the item ending its window, image_cols+1 items after its pixel.
// Each item does one read-modify-write of the two line stores (one read and
// one write port, MAX_COLS words each); back-to-back hits on one column forward.
// Reset needs no clearing pass: stale line store words only sit outside the image.
// A two-entry output buffer absorbs out_stall; in_stall rises only when both
// entries are full and nothing leaves.
`default_nettype none

module zero_crossing_slope_3x3 import zcs_pkg::*; #(
  parameter int MAX_COLS = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire zcs_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output zcs_out_t                   out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CIW  = $clog2(MAX_COLS);
  localparam int COLW = $clog2(MAX_COLS + 1);

  // configuration
  logic [ROWS_W-1:0] rows_r, rows_nxt;
  logic [COLW-1:0]   cols_r, cols_nxt;
  zcs_mode_t         mode_r, mode_nxt;
  logic              restart;

  // positions
  logic [CIW-1:0]    in_col_r, in_col_nxt;
  logic [ROWS_W-1:0] in_row_r, in_row_nxt;
  logic [CIW-1:0]    em_col_r, em_col_nxt;
  logic [ROWS_W-1:0] em_row_r, em_row_nxt;
  logic [CIW-1:0]    cols_last;
  logic [ROWS_W-1:0] rows_last;

  // accept stage
  logic      en;
  logic      acc;
  logic      past_end;
  logic      take;
  logic      go;
  logic      emit;
  logic      em_last;
  pix_t      x;
  zcs_mask_t mask;

  // line store stage
  logic      s1_valid_r;
  logic      s1_emit_r;
  logic      s1_last_r;
  zcs_mask_t s1_mask_r;
  pix_t      s1_x_r;
  logic [CIW-1:0] s1_addr_r;
  logic      fwd_r;
  pix_t      fwd_mid_r;
  pix_t      fwd_up_r;
  pix_t      rd_mid;
  pix_t      rd_up;
  pix_t      mid_eff;
  pix_t      up_eff;

  // window stage
  pix_t      win_r [3][3];
  pix_t      wm [3][3];
  logic      s2_valid_r;
  logic      s2_last_r;
  zcs_mask_t s2_mask_r;
  nbr_arr_t  nbrs;

  // result and output buffer
  logic      res_valid;
  zcs_out_t  res;
  logic      push;
  logic      pop;
  logic [1:0] cnt_r, cnt_nxt;
  zcs_out_t  head_r;
  zcs_out_t  skid_r;

  assign cols_last = CIW'(cols_r - COLW'(1));
  assign rows_last = rows_r - ROWS_W'(1);

  // ---------------- configuration ----------------
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    mode_nxt = mode_r;
    restart  = 1'b0;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_ROWS: begin
          restart = 1'b1;
          if (cfg_wdata[ROWS_W-1:0] == '0) rows_nxt = ROWS_W'(1);
          else if (cfg_wdata[ROWS_W-1:0] > MAX_ROWS) rows_nxt = MAX_ROWS;
          else rows_nxt = cfg_wdata[ROWS_W-1:0];
        end
        REG_IMAGE_COLS: begin
          restart = 1'b1;
          if (cfg_wdata[COLS_CFG_W-1:0] == '0) cols_nxt = COLW'(1);
          else if (32'(cfg_wdata[COLS_CFG_W-1:0]) > 32'(MAX_COLS)) cols_nxt = COLW'(MAX_COLS);
          else cols_nxt = COLW'(cfg_wdata[COLS_CFG_W-1:0]);
        end
        REG_ZERO_THRESHOLD: mode_nxt.thr            = cfg_wdata[THR_W-1:0];
        REG_NEGATIVE_MODE:  mode_nxt.negative_mode  = cfg_wdata[0];
        REG_MARK_ONE_SIDED: mode_nxt.mark_one_sided = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------- accept stage ----------------
  assign pop      = (cnt_r != 2'd0) && !out_stall;
  assign en       = (cnt_r != 2'd2) || pop;
  assign in_stall = !en;
  assign acc      = in_valid && en;

  assign past_end = in_row_r >= rows_r;
  // pixels past the frame and drains before its end are dropped
  assign take     = in_data.action ? (past_end && (em_row_r < rows_r)) : !past_end;
  assign go       = acc && take;
  assign emit     = (in_row_r >= ROWS_W'(2)) || (in_row_r == ROWS_W'(1) && in_col_r != '0);
  assign em_last  = (em_row_r == rows_last) && (em_col_r == cols_last);
  assign x        = in_data.action ? pix_t'(0) : in_data.pixel_value;

  assign mask.top    = em_row_r != '0;
  assign mask.bottom = em_row_r != rows_last;
  assign mask.left   = em_col_r != '0;
  assign mask.right  = em_col_r != cols_last;

  always_comb begin
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    em_col_nxt = em_col_r;
    em_row_nxt = em_row_r;
    if (go) begin
      if (in_col_r == cols_last) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROWS_W'(1);
      end else begin
        in_col_nxt = in_col_r + CIW'(1);
      end
      if (emit) begin
        if (em_col_r == cols_last) begin
          em_col_nxt = '0;
          em_row_nxt = em_row_r + ROWS_W'(1);
        end else begin
          em_col_nxt = em_col_r + CIW'(1);
        end
        if (em_last) begin
          in_col_nxt = '0;
          in_row_nxt = '0;
          em_col_nxt = '0;
          em_row_nxt = '0;
        end
      end
    end
    if (restart) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
      em_col_nxt = '0;
      em_row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= ROWS_W'(1);
      cols_r   <= COLW'(1);
      mode_r   <= '0;
      in_col_r <= '0;
      in_row_r <= '0;
      em_col_r <= '0;
      em_row_r <= '0;
    end else begin
      rows_r   <= rows_nxt;
      cols_r   <= cols_nxt;
      mode_r   <= mode_nxt;
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      em_col_r <= em_col_nxt;
      em_row_r <= em_row_nxt;
    end
  end

  // ---------------- line store read-modify-write ----------------
  zcs_line_store #(
    .DEPTH (MAX_COLS)
  ) u_line_store (
    .clk         (clk),
    .rd_en       (en),
    .rd_addr     (in_col_r),
    .rd_middle_r (rd_mid),
    .rd_upper_r  (rd_up),
    .wr_en       (en && s1_valid_r),
    .wr_addr     (s1_addr_r),
    .wr_middle   (s1_x_r),
    .wr_upper    (mid_eff)
  );

  // a read that meets the previous item's write on the same column
  // (single-column frames) takes the data being written
  assign mid_eff = fwd_r ? fwd_mid_r : rd_mid;
  assign up_eff  = fwd_r ? fwd_up_r  : rd_up;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (en) begin
      s1_valid_r <= go;
      fwd_r      <= s1_valid_r && (s1_addr_r == in_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_emit_r <= emit;
      s1_last_r <= em_last;
      s1_mask_r <= mask;
      s1_x_r    <= x;
      s1_addr_r <= in_col_r;
      fwd_mid_r <= s1_x_r;
      fwd_up_r  <= mid_eff;
    end
  end

  // ---------------- window ----------------
  // row 0 upper line, row 1 middle line, row 2 current row;
  // column 0 newest (right of center), column 2 oldest (left)
  always_ff @(posedge clk) begin
    if (en && s1_valid_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][2] <= win_r[r][1];
        win_r[r][1] <= win_r[r][0];
      end
      win_r[0][0] <= up_eff;
      win_r[1][0] <= mid_eff;
      win_r[2][0] <= s1_x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_last_r <= s1_last_r;
      s2_mask_r <= s1_mask_r;
    end
  end

  // wm is in image orientation: wm[row][col], col 0 on the left
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        wm[r][c] = win_r[r][2-c];
        if ((r == 0 && !s2_mask_r.top) || (r == 2 && !s2_mask_r.bottom) ||
            (c == 0 && !s2_mask_r.left) || (c == 2 && !s2_mask_r.right)) begin
          wm[r][c] = '0;
        end
      end
    end
  end

  assign nbrs = {wm[0][0], wm[0][1], wm[0][2], wm[1][0],
                 wm[1][2], wm[2][0], wm[2][1], wm[2][2]};

  zcs_slope_unit u_slope_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .win_valid (s2_valid_r),
    .win_last  (s2_last_r),
    .center    (wm[1][1]),
    .nbrs      (nbrs),
    .mode      (mode_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // ---------------- output buffer ----------------
  assign push    = en && res_valid;
  assign cnt_nxt = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop)) begin
        head_r <= res;
      end else if (cnt_r == 2'd1) begin
        skid_r <= res;
      end else begin
        head_r <= skid_r;
        skid_r <= res;
      end
    end else if (pop && cnt_r == 2'd2) begin
      head_r <= skid_r;
    end
  end

  assign out_valid = cnt_r != 2'd0;
  assign out_data  = head_r;

endmodule

`default_nettype wire

### src/zcs_line_store.sv
// Two line stores (middle and upper row) with registered read data.
`default_nettype none

module zcs_line_store import zcs_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output pix_t                          rd_middle_r,
  output pix_t                          rd_upper_r,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire pix_t                     wr_middle,
  input  wire pix_t                     wr_upper
);

  pix_t middle_mem [DEPTH];
  pix_t upper_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      middle_mem[wr_addr] <= wr_middle;
      upper_mem[wr_addr]  <= wr_upper;
    end
    if (rd_en) begin
      rd_middle_r <= middle_mem[rd_addr];
      rd_upper_r  <= upper_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### src/zcs_slope_unit.sv
// Neighbor min/max stage and slope decision for one 3x3 window.
`default_nettype none

module zcs_slope_unit import zcs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire logic      win_valid,
  input  wire logic      win_last,
  input  wire pix_t      center,
  input  wire nbr_arr_t  nbrs,
  input  wire zcs_mode_t mode,
  output logic           res_valid,
  output zcs_out_t       res
);

  localparam int EXT_W = PIXEL_W + 3;

  pix_t nmin_nxt;
  pix_t pmax_nxt;
  pix_t nmin_r;
  pix_t pmax_r;
  pix_t ctr_r;
  logic vld_r;
  logic last_r;

  logic signed [EXT_W-1:0] v_e;
  logic signed [EXT_W-1:0] nmin_e;
  logic signed [EXT_W-1:0] pmax_e;
  logic signed [EXT_W-1:0] thr_e;
  logic signed [EXT_W-1:0] slope_e;
  logic                    pos;
  logic                    neg;

  // extremes taken together with zero
  always_comb begin
    nmin_nxt = '0;
    pmax_nxt = '0;
    for (int k = 0; k < NBR_N; k++) begin
      if (nbrs[k] < nmin_nxt) nmin_nxt = nbrs[k];
      if (nbrs[k] > pmax_nxt) pmax_nxt = nbrs[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nmin_r <= nmin_nxt;
      pmax_r <= pmax_nxt;
      ctr_r  <= center;
      last_r <= win_last;
    end
  end

  always_comb begin
    v_e     = EXT_W'(ctr_r);
    nmin_e  = EXT_W'(nmin_r);
    pmax_e  = EXT_W'(pmax_r);
    thr_e   = signed'(EXT_W'(mode.thr));
    pos     = pmax_e > thr_e;
    neg     = nmin_e < -thr_e;
    slope_e = '0;
    if (v_e > thr_e && !mode.negative_mode) begin
      if (neg) slope_e = (v_e - nmin_e) <<< 1;
    end else if (v_e < -thr_e && mode.negative_mode) begin
      if (pos) slope_e = (pmax_e - v_e) <<< 1;
    end else if (v_e > -thr_e && v_e < thr_e) begin
      if ((pos && neg) || (mode.mark_one_sided && (pos || neg))) slope_e = pmax_e - nmin_e;
    end
  end

  assign res_valid      = vld_r;
  assign res.slope      = slope_e[SLOPE_W-1:0];
  assign res.frame_last = last_r;

endmodule

`default_nettype wire

### src/zcs_checker.sv
// Port-level checks for the zero crossing slope block, bound to the top level.
`default_nettype none

module zcs_checker import zcs_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire zcs_out_t out_data
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input backs up only when the output buffer is stuck
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  a_slope_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.slope != {SLOPE_W{1'b1}})
    else $error("slope out of range");

  a_no_x_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_stall))
    else $error("in_stall unknown");

endmodule

bind zero_crossing_slope_3x3 zcs_checker u_zcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
